[hdl/tvs_pkg.sv]
package tvs_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;
  localparam int ENTRY_W       = VALUE_W + 1;
  localparam int COUNT_OUT_W   = 7;
  localparam int OP_W          = 2;

  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
  localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_PUSH_OK,
    RES_PUSH_OVF,
    RES_READ_OK,
    RES_FAIL,
    RES_REV_OK
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      push_wr;
    logic      rd_top;
    logic      pop_dec;
    logic      rev_init;
    logic      swap_rd;
    logic      wr_lo;
    logic      wr_hi;
    res_kind_t res;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            more_swaps;
  } stat_t;

endpackage

[hdl/tvs_ctrl.sv]
module tvs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tvs_pkg::stat_t stat,
  output tvs_pkg::cmd_t  cmd,
  output logic          busy
);

  typedef enum logic [2:0] {
    IDLE,
    DECODE,
    READ_WAIT,
    SWAP_CHK,
    SWAP_WR_LO,
    SWAP_WR_HI
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.res    = tvs_pkg::RES_NONE;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        unique case (stat.op) inside
          tvs_pkg::OP_PUSH: begin
            if (stat.full) begin
              cmd.res = tvs_pkg::RES_PUSH_OVF;
            end else begin
              cmd.push_wr = 1'b1;
              cmd.res     = tvs_pkg::RES_PUSH_OK;
            end
            state_next = IDLE;
          end
          tvs_pkg::OP_POP, tvs_pkg::OP_PEEK: begin
            if (stat.empty) begin
              cmd.res    = tvs_pkg::RES_FAIL;
              state_next = IDLE;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = READ_WAIT;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.res    = tvs_pkg::RES_FAIL;
              state_next = IDLE;
            end else begin
              cmd.rev_init = 1'b1;
              state_next   = SWAP_CHK;
            end
          end
        endcase
      end
      READ_WAIT: begin
        cmd.res     = tvs_pkg::RES_READ_OK;
        cmd.pop_dec = (stat.op == tvs_pkg::OP_POP);
        state_next  = IDLE;
      end
      SWAP_CHK: begin
        // read both ends, or finish once they meet
        if (stat.more_swaps) begin
          cmd.swap_rd = 1'b1;
          state_next  = SWAP_WR_LO;
        end else begin
          cmd.res    = tvs_pkg::RES_REV_OK;
          state_next = IDLE;
        end
      end
      SWAP_WR_LO: begin
        cmd.wr_lo  = 1'b1;
        state_next = SWAP_WR_HI;
      end
      SWAP_WR_HI: begin
        cmd.wr_hi  = 1'b1;
        state_next = SWAP_CHK;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

endmodule

[hdl/tvs_datapath.sv]
module tvs_datapath #(
  parameter int DEPTH = tvs_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tvs_pkg::cmd_t                       cmd,
  output tvs_pkg::stat_t                      stat,
  input  logic [tvs_pkg::OP_W-1:0]            operation,
  input  logic                                in_is_int,
  input  logic signed [tvs_pkg::VALUE_W-1:0]  in_value,
  output logic                                done,
  output logic                                ok,
  output logic                                out_is_int,
  output logic signed [tvs_pkg::VALUE_W-1:0]  out_value,
  output logic                                overflow,
  output logic [tvs_pkg::COUNT_OUT_W-1:0]     entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [tvs_pkg::ENTRY_W-1:0] mem [DEPTH];

  logic [tvs_pkg::OP_W-1:0]    op;
  logic [tvs_pkg::ENTRY_W-1:0] entry;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [CW-1:0]               count_dec;
  logic [AW-1:0]               lo;
  logic [AW-1:0]               hi;
  logic [AW-1:0]               addr_a;
  logic [tvs_pkg::ENTRY_W-1:0] rd_a;
  logic [tvs_pkg::ENTRY_W-1:0] rd_b;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [tvs_pkg::ENTRY_W-1:0] wr_data;
  logic [CW+tvs_pkg::COUNT_OUT_W-1:0] count_ext;

  assign count_dec = count - CW'(1);

  assign stat.op         = op;
  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CW'(DEPTH));
  assign stat.more_swaps = (lo < hi);

  always_comb begin
    count_next = count;
    if (cmd.push_wr) begin
      count_next = count + CW'(1);
    end else if (cmd.pop_dec) begin
      count_next = count_dec;
    end
  end

  assign count_ext = {{tvs_pkg::COUNT_OUT_W{1'b0}}, count_next};

  assign addr_a = cmd.rd_top ? count_dec[AW-1:0] : lo;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lo;
    wr_data = rd_b;
    if (cmd.push_wr) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = entry;
    end else if (cmd.wr_lo) begin
      wr_en   = 1'b1;
      wr_addr = lo;
      wr_data = rd_b;
    end else if (cmd.wr_hi) begin
      wr_en   = 1'b1;
      wr_addr = hi;
      wr_data = rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_top || cmd.swap_rd) begin
      rd_a <= mem[addr_a];
    end
    if (cmd.swap_rd) begin
      rd_b <= mem[hi];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= operation;
      entry <= {in_is_int, in_value};
    end
    if (cmd.rev_init) begin
      lo <= '0;
      hi <= count_dec[AW-1:0];
    end else if (cmd.wr_hi) begin
      // advance both ends inward after the swap
      lo <= lo + AW'(1);
      hi <= hi - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= (cmd.res != tvs_pkg::RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res != tvs_pkg::RES_NONE) begin
      ok          <= (cmd.res == tvs_pkg::RES_PUSH_OK) || (cmd.res == tvs_pkg::RES_READ_OK)
                     || (cmd.res == tvs_pkg::RES_REV_OK);
      overflow    <= (cmd.res == tvs_pkg::RES_PUSH_OVF);
      entry_count <= count_ext[tvs_pkg::COUNT_OUT_W-1:0];
      if (cmd.res == tvs_pkg::RES_READ_OK) begin
        out_is_int <= rd_a[tvs_pkg::ENTRY_W-1];
        out_value  <= rd_a[tvs_pkg::VALUE_W-1:0];
      end else begin
        out_is_int <= 1'b0;
        out_value  <= '0;
      end
    end
  end

endmodule

[hdl/tagged_value_stack.sv]
// Push and failed operations: the result is decided in DECODE and registered onto done.
// Pop and peek: the result is issued in READ_WAIT, set by the registered memory read.
// Reverse of n entries: floor(n/2) swaps, one read and two writes per swap
// on the single write port. One item at a time; busy stays high until the result.
// Results are shown for one cycle on done; the receiver cannot stall.
// Synchronous reset empties the stack; stored entries are not cleared.
module tagged_value_stack #(
  parameter int DEPTH = tvs_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [tvs_pkg::OP_W-1:0]            operation,
  input  logic                                in_is_int,
  input  logic signed [tvs_pkg::VALUE_W-1:0]  in_value,
  output logic                                done,
  output logic                                ok,
  output logic                                out_is_int,
  output logic signed [tvs_pkg::VALUE_W-1:0]  out_value,
  output logic                                overflow,
  output logic [tvs_pkg::COUNT_OUT_W-1:0]     entry_count
);

  tvs_pkg::cmd_t  cmd;
  tvs_pkg::stat_t stat;

  tvs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tvs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .in_is_int   (in_is_int),
    .in_value    (in_value),
    .done        (done),
    .ok          (ok),
    .out_is_int  (out_is_int),
    .out_value   (out_value),
    .overflow    (overflow),
    .entry_count (entry_count)
  );

endmodule
